>>> sv/bdc_pkg.sv
// Shared types, constants and calendar helpers for the business day counter.
`timescale 1ns / 1ps

package bdc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;
    localparam int MASK_W  = 7;

    // Day serial numbers since 0001-01-01 stay below 2^22 for years up to 9999.
    localparam int SER_W   = 22;
    localparam int DVS_W   = 9;

    localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;

    localparam logic [DVS_W-1:0] DVS_100 = 9'd100;
    localparam logic [DVS_W-1:0] DVS_400 = 9'd400;
    localparam logic [DVS_W-1:0] DVS_7   = 9'd7;

    // Reciprocals: (x * RCP) >> SH is exact for x < 2^14 (by 100 and 400)
    // and for x < 2^22 (by 7), which covers every dividend the sequencer issues.
    localparam int               RCP_W   = 24;
    localparam logic [RCP_W-1:0] RCP_100 = 24'd5243;
    localparam logic [RCP_W-1:0] RCP_400 = 24'd5243;
    localparam logic [RCP_W-1:0] RCP_7   = 24'd9586981;
    localparam int               SH_100  = 19;
    localparam int               SH_400  = 21;
    localparam int               SH_7    = 26;

    typedef struct packed {
        logic                  start;
        logic [SER_W-1:0]      dividend;
        logic [DVS_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [SER_W-1:0]      quo;
        logic [DVS_W-1:0]      rem;
    } t_div_rsp;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year ahead of the first of month m, common year.
    function automatic logic [8:0] month_before(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        unique case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> sv/bdc_div.sv
// Shared constant divider: reciprocal multiply on one multiplier, four steps per division.
`timescale 1ns / 1ps

module bdc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdc_pkg::t_div_req i_req,
    output bdc_pkg::t_div_rsp o_rsp
);
    import bdc_pkg::*;

    localparam int PROD_W = SER_W + RCP_W;

    // Steps of one division
    localparam logic [1:0] STEP_MUL   = 2'd0;  // x * reciprocal
    localparam logic [1:0] STEP_SHIFT = 2'd1;  // quotient from the product
    localparam logic [1:0] STEP_BACK  = 2'd2;  // quotient * divisor
    localparam logic [1:0] STEP_REM   = 2'd3;  // remainder
    localparam logic [1:0] LAST_STEP  = STEP_REM;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_cnt;
    logic [SER_W-1:0]  r_x;
    logic [DVS_W-1:0]  r_dvs;
    logic [RCP_W-1:0]  r_rcp;
    logic [PROD_W-1:0] r_prod;
    logic [SER_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;

    logic              w_load;
    logic [RCP_W-1:0]  w_rcp;
    logic [SER_W-1:0]  w_mul_a;
    logic [RCP_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [SER_W-1:0]  w_quo;
    logic [SER_W-1:0]  w_diff;

    assign w_load = i_req.start && !r_busy;

    always_comb begin
        unique case (i_req.divisor)
            DVS_400: w_rcp = RCP_400;
            DVS_7:   w_rcp = RCP_7;
            default: w_rcp = RCP_100;
        endcase
    end

    // One multiplier: x * reciprocal first, then quotient * divisor
    assign w_mul_a = (r_cnt == STEP_BACK) ? r_quo : r_x;
    assign w_mul_b = (r_cnt == STEP_BACK) ? RCP_W'(r_dvs) : r_rcp;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    always_comb begin
        unique case (r_dvs)
            DVS_400: w_quo = SER_W'(r_prod >> SH_400);
            DVS_7:   w_quo = SER_W'(r_prod >> SH_7);
            default: w_quo = SER_W'(r_prod >> SH_100);
        endcase
    end

    assign w_diff = r_x - r_prod[SER_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x   <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rcp <= w_rcp;
        end else if (r_busy) begin
            unique case (r_cnt)
                STEP_MUL, STEP_BACK: r_prod <= w_prod;
                STEP_SHIFT:          r_quo  <= w_quo;
                STEP_REM:            r_rem  <= w_diff[DVS_W-1:0];
            endcase
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

endmodule

>>> sv/bdc_tally.sv
// Final count: whole weeks times open days, plus the open days of the partial week, saturated at 65535.
`timescale 1ns / 1ps

module bdc_tally (
    input  logic [18:0]                 i_weeks,
    input  logic [2:0]                  i_rest,
    input  logic [2:0]                  i_wday0,
    input  logic [bdc_pkg::MASK_W-1:0]  i_mask,
    output logic [bdc_pkg::COUNT_W-1:0] o_count
);
    import bdc_pkg::*;

    logic [2:0]       w_per_week;
    logic [2:0]       w_part;
    logic [3:0]       w_sum;
    logic [2:0]       w_day;
    logic [SER_W-1:0] w_total;

    assign w_per_week = 3'd7 - 3'($countones(i_mask));

    always_comb begin
        w_part = '0;
        w_sum  = '0;
        w_day  = '0;
        for (int k = 0; k < 6; k++) begin
            w_sum = {1'b0, i_wday0} + 4'(k);
            w_day = (w_sum >= 4'd7) ? 3'(w_sum - 4'd7) : w_sum[2:0];
            if ((3'(k) < i_rest) && !i_mask[w_day])
                w_part = w_part + 3'd1;
        end
    end

    assign w_total = (SER_W'(i_weeks) * SER_W'(w_per_week)) + SER_W'(w_part);
    assign o_count = (w_total > SER_W'(16'hFFFF)) ? 16'hFFFF : w_total[COUNT_W-1:0];

endmodule

>>> sv/business_day_counter_top.sv
// Business day counter top level: sequencer around a shared constant divider.
`timescale 1ns / 1ps

// Counts the business days from a start date (included) to an end date
// (excluded) in the Gregorian calendar; a weekday whose bit is set in the
// weekend mask is not a business day (Sunday is bit 0, reset mask is Friday
// and Saturday). A word is taken when start is high and busy is low; busy then
// stays high until the result is out. The result shows for exactly one cycle
// with o_valid and cannot be held off, so capture it on that cycle. An item
// runs the shared divider (a four-step reciprocal multiply) twice per date
// (by 100 and 400) and, when both dates are good and start is before end,
// twice more by 7 (span length and start weekday). A bad date gives a count
// of 0 with o_bad_date set; an empty or reversed span gives 0. The count
// saturates at 65535. Write the mask only while busy is low.

module business_day_counter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_weekend_mask_we,
    input  logic [bdc_pkg::MASK_W-1:0]   i_weekend_mask,
    input  logic                         start,
    output logic                         busy,
    input  logic [bdc_pkg::YEAR_W-1:0]   i_from_year,
    input  logic [bdc_pkg::MONTH_W-1:0]  i_from_month,
    input  logic [bdc_pkg::DAY_W-1:0]    i_from_day,
    input  logic [bdc_pkg::YEAR_W-1:0]   i_to_year,
    input  logic [bdc_pkg::MONTH_W-1:0]  i_to_month,
    input  logic [bdc_pkg::DAY_W-1:0]    i_to_day,
    output logic                         o_valid,
    output logic [bdc_pkg::COUNT_W-1:0]  o_business_days,
    output logic                         o_bad_date
);
    import bdc_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV100 = 3'd1;  // p/100, also 365p + p/4 into acc
    localparam logic [2:0] S_DIV400 = 3'd2;  // p/400
    localparam logic [2:0] S_SERIAL = 3'd3;  // finish serial day, check date
    localparam logic [2:0] S_DIFF   = 3'd4;  // span length, early exits
    localparam logic [2:0] S_DIVN   = 3'd5;  // span / 7
    localparam logic [2:0] S_DIVW   = 3'd6;  // (start serial + 1) % 7 = weekday
    localparam logic [2:0] S_TALLY  = 3'd7;

    logic [2:0]         r_state;
    logic [2:0]         n_state;

    // Latched request
    logic [YEAR_W-1:0]  r_fy, r_ty;
    logic [MONTH_W-1:0] r_fm, r_tm;
    logic [DAY_W-1:0]   r_fd, r_td;

    logic               r_sel;      // 0: start date, 1: end date
    logic               r_bad;
    logic [SER_W-1:0]   r_acc;
    logic [6:0]         r_q100;
    logic [6:0]         r_r100;
    logic [SER_W-1:0]   r_s;
    logic [SER_W-1:0]   r_e;
    logic [SER_W-1:0]   r_n;
    logic [18:0]        r_q7;
    logic [2:0]         r_r7;

    logic [MASK_W-1:0]  r_mask;
    logic               r_valid;
    logic [COUNT_W-1:0] r_count;
    logic               r_bad_out;

    t_div_req           w_req;
    t_div_rsp           w_rsp;

    logic [YEAR_W-1:0]  w_y;
    logic [MONTH_W-1:0] w_m;
    logic [DAY_W-1:0]   w_d;
    logic [YEAR_W-1:0]  w_p;
    logic [SER_W-1:0]   w_p_ext;
    logic [SER_W-1:0]   w_base;
    logic               w_leap;
    logic               w_date_ok;
    logic [SER_W-1:0]   w_serial;
    logic               w_div_state;
    logic [COUNT_W-1:0] w_tally;

    // Date under work and its year-minus-one
    assign w_y     = r_sel ? r_ty : r_fy;
    assign w_m     = r_sel ? r_tm : r_fm;
    assign w_d     = r_sel ? r_td : r_fd;
    assign w_p     = w_y - 14'd1;
    assign w_p_ext = SER_W'(w_p);
    assign w_base  = (w_p_ext * SER_W'(365)) + (w_p_ext >> 2);

    // y is a leap year when p % 400 == 399, or p % 4 == 3 and p % 100 != 99
    assign w_leap = (w_rsp.rem == 9'd399) ||
                    ((w_p[1:0] == 2'b11) && (r_r100 != 7'd99));

    assign w_date_ok = (w_y != '0) && (w_y <= YEAR_MAX) &&
                       (w_m != '0) && (w_m <= 4'd12) &&
                       (w_d != '0) && (w_d <= month_len(w_m, w_leap));

    assign w_serial = r_acc - SER_W'(r_q100) + SER_W'(w_rsp.quo[4:0])
                      + SER_W'(month_before(w_m))
                      + SER_W'((w_m > 4'd2) && w_leap)
                      + SER_W'(w_d) - SER_W'(1);

    // Divider request
    assign w_div_state = (r_state == S_DIV100) || (r_state == S_DIV400) ||
                         (r_state == S_DIVN) || (r_state == S_DIVW);

    always_comb begin
        w_req.start    = w_div_state && !w_rsp.busy && !w_rsp.done;
        w_req.dividend = w_p_ext;
        w_req.divisor  = DVS_100;
        unique case (r_state)
            S_DIV400: w_req.divisor = DVS_400;
            S_DIVN: begin
                w_req.dividend = r_n;
                w_req.divisor  = DVS_7;
            end
            S_DIVW: begin
                w_req.dividend = r_s + SER_W'(1);
                w_req.divisor  = DVS_7;
            end
            default: ;
        endcase
    end

    bdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Weekday of the start date is the divider remainder while in S_TALLY
    bdc_tally u_tally (
        .i_weeks (r_q7),
        .i_rest  (r_r7),
        .i_wday0 (w_rsp.rem[2:0]),
        .i_mask  (r_mask),
        .o_count (w_tally)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_DIV100;
            S_DIV100: if (w_rsp.done) n_state = S_DIV400;
            S_DIV400: if (w_rsp.done) n_state = S_SERIAL;
            S_SERIAL: n_state = r_sel ? S_DIFF : S_DIV100;
            S_DIFF:   n_state = (r_bad || (r_s >= r_e)) ? S_IDLE : S_DIVN;
            S_DIVN:   if (w_rsp.done) n_state = S_DIVW;
            S_DIVW:   if (w_rsp.done) n_state = S_TALLY;
            S_TALLY:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= MASK_RESET;
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_weekend_mask_we)
                r_mask <= i_weekend_mask;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_sel <= 1'b0;
                        r_bad <= 1'b0;
                    end
                end
                S_SERIAL: begin
                    r_sel <= 1'b1;
                    if (!w_date_ok)
                        r_bad <= 1'b1;
                end
                S_DIFF:  if (r_bad || (r_s >= r_e)) r_valid <= 1'b1;
                S_TALLY: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_fy <= i_from_year;
                    r_fm <= i_from_month;
                    r_fd <= i_from_day;
                    r_ty <= i_to_year;
                    r_tm <= i_to_month;
                    r_td <= i_to_day;
                end
            end
            S_DIV100: begin
                r_acc <= w_base;
                if (w_rsp.done) begin
                    r_q100 <= w_rsp.quo[6:0];
                    r_r100 <= w_rsp.rem[6:0];
                end
            end
            S_SERIAL: begin
                if (r_sel)
                    r_e <= w_serial;
                else
                    r_s <= w_serial;
            end
            S_DIFF: begin
                r_n       <= r_e - r_s;
                r_count   <= '0;
                r_bad_out <= r_bad;
            end
            S_DIVN: begin
                if (w_rsp.done) begin
                    r_q7 <= w_rsp.quo[18:0];
                    r_r7 <= w_rsp.rem[2:0];
                end
            end
            S_TALLY: begin
                r_count   <= w_tally;
                r_bad_out <= 1'b0;
            end
            default: ;
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_business_days = r_count;
    assign o_bad_date      = r_bad_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_DIFF || r_state == S_TALLY) && !busy)
        else $error("result strobe outside the finish states");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_date |-> o_business_days == '0)
        else $error("bad date with nonzero count");

endmodule

>>> bench/business_day_counter_checker.sv
// Checker for the business day counter: predicts each result word and compares it.
`timescale 1ns / 1ps

module business_day_counter_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_mask_we,
    input  logic [bdc_pkg::MASK_W-1:0]   i_mask_wdata,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [bdc_pkg::YEAR_W-1:0]   i_from_year,
    input  logic [bdc_pkg::MONTH_W-1:0]  i_from_month,
    input  logic [bdc_pkg::DAY_W-1:0]    i_from_day,
    input  logic [bdc_pkg::YEAR_W-1:0]   i_to_year,
    input  logic [bdc_pkg::MONTH_W-1:0]  i_to_month,
    input  logic [bdc_pkg::DAY_W-1:0]    i_to_day,
    input  logic                         i_valid,
    input  logic [bdc_pkg::COUNT_W-1:0]  i_business_days,
    input  logic                         i_bad_date,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_bad_seen,
    output int                           o_sat_seen
);

    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned LAST_YEAR     = 9999;
    localparam logic [bdc_pkg::COUNT_W-1:0] COUNT_CEILING = '1;

    typedef struct packed {
        logic [bdc_pkg::COUNT_W-1:0] days;
        logic                        bad;
    } tally_t;

    logic [bdc_pkg::MASK_W-1:0] weekend_bits;
    tally_t                     open_tally [$];

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_good(input int unsigned y, input int unsigned m,
                                     input int unsigned d);
        if (y < 1 || y > LAST_YEAR || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= days_in_month(y, m);
    endfunction

    // Days since 0001-01-01.
    function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += days_in_month(y, k);
        return n + d - 1;
    endfunction

    // Sunday is 0.
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % DAYS_PER_WEEK;
    endfunction

    function automatic tally_t predict_tally(input logic [bdc_pkg::MASK_W-1:0] mask,
                                             input int unsigned fy, input int unsigned fm,
                                             input int unsigned fd, input int unsigned ty,
                                             input int unsigned tm, input int unsigned td);
        tally_t      r;
        int unsigned s;
        int unsigned e;
        int unsigned span;
        int unsigned w0;
        int unsigned open_days;
        longint      total;
        r = '0;
        if (!date_good(fy, fm, fd) || !date_good(ty, tm, td)) begin
            r.bad = 1'b1;
            return r;
        end
        s = day_number(fy, fm, fd);
        e = day_number(ty, tm, td);
        if (s >= e)
            return r;
        span      = e - s;
        open_days = 0;
        for (int unsigned k = 0; k < DAYS_PER_WEEK; k++)
            if (!mask[k])
                open_days++;
        total = longint'(span / DAYS_PER_WEEK) * open_days;
        w0    = day_of_week(fy, fm, fd);
        for (int unsigned k = 0; k < span % DAYS_PER_WEEK; k++)
            if (!mask[(w0 + k) % DAYS_PER_WEEK])
                total++;
        r.days = (total > longint'(COUNT_CEILING)) ? COUNT_CEILING : total[15:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_bad_seen   = 0;
        o_sat_seen   = 0;
        weekend_bits = bdc_pkg::MASK_RESET;
    end

    always @(posedge i_clk) begin : watch
        tally_t want;
        if (!i_rst_n) begin
            weekend_bits = bdc_pkg::MASK_RESET;
            open_tally.delete();
        end else begin
            // result side first: a word accepted on this edge cannot answer itself
            if (i_valid === 1'b1) begin
                if (open_tally.size() == 0) begin
                    $error("result word with nothing outstanding: days %0d bad %0b",
                           i_business_days, i_bad_date);
                    o_fail_count++;
                end else begin
                    want = open_tally.pop_front();
                    o_checked++;
                    if (i_business_days !== want.days) begin
                        $error("business_days: expected %0d, got %0d",
                               want.days, i_business_days);
                        o_fail_count++;
                    end
                    if (i_bad_date !== want.bad) begin
                        $error("bad_date: expected %0b, got %0b", want.bad, i_bad_date);
                        o_fail_count++;
                    end
                    if (want.bad)
                        o_bad_seen++;
                    if (want.days == COUNT_CEILING)
                        o_sat_seen++;
                end
            end
            if (i_start && !i_busy)
                open_tally.push_back(predict_tally(weekend_bits, i_from_year, i_from_month,
                                                   i_from_day, i_to_year, i_to_month,
                                                   i_to_day));
            // mask register takes effect after this edge
            if (i_mask_we)
                weekend_bits = i_mask_wdata;
        end
        o_pending = open_tally.size();
    end

endmodule

>>> bench/business_day_counter_top_test.sv
// Testbench top for the business day counter: stimulus, mask phases and verdict.
`timescale 1ns / 1ps

module business_day_counter_top_test;

    localparam time CLK_PERIOD     = 10ns;
    localparam int  RESET_CYCLES   = 10;
    // Well above the run time of the slowest path for all 1123 words with their
    // longest gaps, so this leaves ample margin.
    localparam int  CYCLE_LIMIT    = 1_000_000;
    localparam int  SETTLE_CYCLES  = 300;
    localparam int  RANDOM_PHASES  = 7;
    localparam int  WORDS_PER_PHASE = 157;
    localparam int  MAX_GAP        = 17;

    typedef struct packed {
        logic [bdc_pkg::YEAR_W-1:0]  y;
        logic [bdc_pkg::MONTH_W-1:0] m;
        logic [bdc_pkg::DAY_W-1:0]   d;
    } cal_date_t;

    // Weekend masks for the random phases; all-clear and all-set are the extremes.
    localparam logic [bdc_pkg::MASK_W-1:0] MASK_SAT_SUN   = 7'h41;
    localparam logic [bdc_pkg::MASK_W-1:0] MASK_NONE      = 7'h00;
    localparam logic [bdc_pkg::MASK_W-1:0] MASK_ALL       = 7'h7F;
    localparam logic [bdc_pkg::MASK_W-1:0] MASK_WEEKDAYS  = 7'h3E;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_weekend_mask_we;
    logic [bdc_pkg::MASK_W-1:0]   i_weekend_mask;
    logic                         start;
    logic                         busy;
    logic [bdc_pkg::YEAR_W-1:0]   i_from_year;
    logic [bdc_pkg::MONTH_W-1:0]  i_from_month;
    logic [bdc_pkg::DAY_W-1:0]    i_from_day;
    logic [bdc_pkg::YEAR_W-1:0]   i_to_year;
    logic [bdc_pkg::MONTH_W-1:0]  i_to_month;
    logic [bdc_pkg::DAY_W-1:0]    i_to_day;
    logic                         o_valid;
    logic [bdc_pkg::COUNT_W-1:0]  o_business_days;
    logic                         o_bad_date;

    int fail_count;
    int pending;
    int checked;
    int bad_seen;
    int sat_seen;
    int cycle_count = 0;
    int mask_writes = 0;
    bit steady_run  = 1'b0;   // back-to-back words while set

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    business_day_counter_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_weekend_mask_we (i_weekend_mask_we),
        .i_weekend_mask    (i_weekend_mask),
        .start             (start),
        .busy              (busy),
        .i_from_year       (i_from_year),
        .i_from_month      (i_from_month),
        .i_from_day        (i_from_day),
        .i_to_year         (i_to_year),
        .i_to_month        (i_to_month),
        .i_to_day          (i_to_day),
        .o_valid           (o_valid),
        .o_business_days   (o_business_days),
        .o_bad_date        (o_bad_date)
    );

    business_day_counter_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mask_we       (i_weekend_mask_we),
        .i_mask_wdata    (i_weekend_mask),
        .i_start         (start),
        .i_busy          (busy),
        .i_from_year     (i_from_year),
        .i_from_month    (i_from_month),
        .i_from_day      (i_from_day),
        .i_to_year       (i_to_year),
        .i_to_month      (i_to_month),
        .i_to_day        (i_to_day),
        .i_valid         (o_valid),
        .i_business_days (o_business_days),
        .i_bad_date      (o_bad_date),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_bad_seen      (bad_seen),
        .o_sat_seen      (sat_seen)
    );

    // Watchdog: a hung handshake or a lost result word ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles, %0d words outstanding",
                   CYCLE_LIMIT, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic cal_date_t on_date(input int unsigned y, input int unsigned m,
                                          input int unsigned d);
        cal_date_t r;
        r.y = 14'(y);
        r.m = 4'(m);
        r.d = 5'(d);
        return r;
    endfunction

    // Mostly well-formed dates; days 29..31 turn up often enough to hit
    // short months and February in and out of leap years.
    function automatic cal_date_t pick_date(input int unsigned year_lo,
                                            input int unsigned year_hi);
        cal_date_t r;
        r.y = 14'($urandom_range(year_hi, year_lo));
        r.m = 4'($urandom_range(12, 1));
        r.d = 5'(($urandom_range(7, 0) == 0) ? $urandom_range(31, 29)
                                               : $urandom_range(28, 1));
        return r;
    endfunction

    // Raw field bits: covers year 0, years past 9999, month 0/13..15 and day 0.
    function automatic cal_date_t raw_date();
        cal_date_t r;
        r.y = 14'($urandom);
        r.m = 4'($urandom);
        r.d = 5'($urandom);
        return r;
    endfunction

    // Hands one word to the block and returns right after a rising edge;
    // start stays high across back-to-back words and is only dropped for a gap.
    task automatic send_pair(input cal_date_t from_date, input cal_date_t to_date);
        int gap;
        if ($urandom_range(39, 0) == 0)
            steady_run = !steady_run;
        gap = steady_run ? 0 : $urandom_range(MAX_GAP, 0);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_from_year  <= from_date.y;
        i_from_month <= from_date.m;
        i_from_day   <= from_date.d;
        i_to_year    <= to_date.y;
        i_to_month   <= to_date.m;
        i_to_day     <= to_date.d;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // Drop start and wait until every predicted word has come back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy !== 1'b0)
            @(negedge i_clk);
    endtask

    // Only called after drain, so the block is idle.
    task automatic write_mask(input logic [bdc_pkg::MASK_W-1:0] mask);
        i_weekend_mask_we <= 1'b1;
        i_weekend_mask    <= mask;
        @(negedge i_clk);
        i_weekend_mask_we <= 1'b0;
        mask_writes++;
    endtask

    initial begin : stimulus
        cal_date_t                  from_date;
        cal_date_t                  to_date;
        int                         kind;
        logic [bdc_pkg::MASK_W-1:0] phase_mask [RANDOM_PHASES];

        phase_mask[0] = MASK_SAT_SUN;
        phase_mask[1] = MASK_NONE;
        phase_mask[2] = MASK_ALL;
        phase_mask[3] = MASK_WEEKDAYS;
        phase_mask[4] = bdc_pkg::MASK_RESET;
        phase_mask[5] = 7'($urandom);
        phase_mask[6] = 7'($urandom);

        i_rst_n           = 1'b0;
        i_weekend_mask_we = 1'b0;
        i_weekend_mask    = '0;
        start             = 1'b0;
        i_from_year       = '0;
        i_from_month      = '0;
        i_from_day        = '0;
        i_to_year         = '0;
        i_to_month        = '0;
        i_to_day          = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed words, reset mask (Friday and Saturday off) ---
        // full Monday-to-Monday week
        send_pair(on_date(2024, 1, 1), on_date(2024, 1, 8));
        // empty and reversed spans
        send_pair(on_date(2024, 3, 15), on_date(2024, 3, 15));
        send_pair(on_date(2024, 3, 20), on_date(2024, 3, 15));
        // whole calendar range, saturates; then a one-day span at the top end
        send_pair(on_date(1, 1, 1), on_date(9999, 12, 31));
        send_pair(on_date(9999, 12, 30), on_date(9999, 12, 31));
        // leap days: ordinary leap year, century divisible by 400
        send_pair(on_date(2024, 2, 29), on_date(2024, 3, 1));
        send_pair(on_date(2000, 2, 29), on_date(2000, 3, 4));
        // non-leap February 29, including a century year
        send_pair(on_date(2023, 2, 29), on_date(2023, 3, 1));
        send_pair(on_date(1900, 2, 29), on_date(1900, 3, 1));
        // bad end date only: April 31
        send_pair(on_date(2021, 4, 1), on_date(2021, 4, 31));
        // day 0, month 0, month 13, month 15
        send_pair(on_date(2020, 1, 31), on_date(2020, 5, 0));
        send_pair(on_date(2020, 0, 10), on_date(2020, 2, 1));
        send_pair(on_date(2020, 13, 1), on_date(2021, 2, 1));
        send_pair(on_date(2020, 15, 31), on_date(2021, 2, 1));
        // year 0, year just past range, all field bits set
        send_pair(on_date(0, 6, 1), on_date(2020, 2, 1));
        send_pair(on_date(9999, 1, 1), on_date(10000, 1, 1));
        send_pair(on_date(16383, 15, 31), on_date(16383, 15, 31));
        // first year: weekday formula with a year of zero after the shift
        send_pair(on_date(1, 1, 1), on_date(1, 3, 1));
        // partial week starting on a weekend day
        send_pair(on_date(2024, 1, 6), on_date(2024, 1, 9));
        // bad date wins over a reversed span
        send_pair(on_date(2022, 6, 31), on_date(2022, 6, 1));
        drain();

        // every weekday off: counts are always zero
        write_mask(MASK_ALL);
        send_pair(on_date(2024, 1, 1), on_date(2025, 1, 1));
        send_pair(on_date(1, 1, 1), on_date(9999, 12, 31));
        drain();

        // no weekend at all
        write_mask(MASK_NONE);
        send_pair(on_date(1, 1, 1), on_date(9999, 12, 31));
        send_pair(on_date(2024, 1, 1), on_date(2024, 1, 4));
        drain();

        // --- random phases, one weekend mask each ---
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_mask(phase_mask[p]);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                kind = $urandom_range(99, 0);
                if (kind < 5)
                    from_date = raw_date();
                else if (kind < 10)
                    from_date = pick_date(1, 3);
                else if (kind < 15)
                    from_date = pick_date(9997, 9999);
                else
                    from_date = pick_date(1, 9999);

                kind = $urandom_range(99, 0);
                if (kind < 55)          // typical span: same or next year
                    to_date = pick_date(from_date.y, from_date.y + 1);
                else if (kind < 70)     // long span, often saturating
                    to_date = pick_date(1, 9999);
                else if (kind < 80)
                    to_date = from_date;
                else if (kind < 92)     // likely reversed
                    to_date = pick_date((from_date.y > 1) ? from_date.y - 1 : 1,
                                        from_date.y);
                else
                    to_date = raw_date();

                send_pair(from_date, to_date);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Checked %0d result words over %0d weekend mask settings.",
                 checked, mask_writes + 1);
        $display("%0d words had an invalid date, %0d counts hit the 16-bit ceiling.",
                 bad_seen, sat_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
